// File: design/case_folded_name_intern_table_top_macros.svh
// Assertion macros used by the checker file
`ifndef CASE_FOLDED_NAME_INTERN_TABLE_TOP_MACROS_SVH
`define CASE_FOLDED_NAME_INTERN_TABLE_TOP_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define CFN_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define CFN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/cfn_pkg.sv
package cfn_pkg;
  localparam int unsigned TableSlotsDef = 256;
  localparam int unsigned MaxAtomsDef   = 128;
  localparam int unsigned MaxNameLenDef = 64;
  localparam int unsigned StoreBytesDef = 4096;

  localparam logic [31:0] FnvOffset = 32'd2166136261;
  localparam logic [31:0] FnvPrime  = 32'd16777619;

  localparam logic [2:0] StFound    = 3'd0;
  localparam logic [2:0] StInserted = 3'd1;
  localparam logic [2:0] StEmpty    = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StLong     = 3'd4;

  // Request handed from front to back
  typedef struct packed {
    logic        lookup;   // 1: run a lookup, 0: emit the fixed status
    logic [2:0]  code;     // status when no lookup runs
    logic [31:0] hash;
    logic [7:0]  len;
  } cfn_req_t;

  function automatic logic [7:0] fold_ascii(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
  endfunction
endpackage

// File: design/cfn_front.sv
// Front: fold, hash and stage name bytes; emit one request per finished name
module cfn_front import cfn_pkg::*; #(
  parameter int unsigned MAX_NAME_LEN = MaxNameLenDef,
  localparam int unsigned NW = $clog2(MAX_NAME_LEN)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     name_byte,
  input  logic           last_byte,
  input  logic           empty_name,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           req_valid,
  output cfn_req_t       req,
  input  logic           req_ready,
  // staging read port for the back part
  input  logic [NW-1:0]  stage_addr,
  output logic [7:0]     stage_data,
  input  logic           stage_release
);
  logic [7:0]  staging_name [MAX_NAME_LEN];
  logic [31:0] running_hash;
  logic [7:0]  byte_count;
  logic        overlong_flag;
  logic        busy;     // staging buffer owned by back part
  logic [7:0]  c;
  logic [31:0] hash_x;
  logic [31:0] hash_next;
  logic        acc;

  assign in_ready = !req_valid && !busy;
  assign acc = in_valid && in_ready;
  assign c = fold_ascii(name_byte);
  assign hash_x = running_hash ^ {24'd0, c};
  assign hash_next = hash_x * FnvPrime;

  // Stage folded bytes
  always_ff @(posedge clk) begin
    if (acc && !empty_name && byte_count < 8'(MAX_NAME_LEN))
      staging_name[byte_count[NW-1:0]] <= c;
    stage_data <= staging_name[stage_addr];
  end

  // Accumulate and hand over
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash  <= FnvOffset;
      byte_count    <= '0;
      overlong_flag <= 1'b0;
      req_valid     <= 1'b0;
      busy          <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        req_valid <= 1'b0;
        busy      <= req.lookup;
      end
      if (stage_release) busy <= 1'b0;
      if (acc) begin
        if (empty_name) begin
          req_valid <= 1'b1;
          req       <= '{lookup: 1'b0, code: StEmpty, hash: '0, len: '0};
          running_hash <= FnvOffset;
          byte_count <= '0;
          overlong_flag <= 1'b0;
        end else if (last_byte) begin
          req_valid <= 1'b1;
          req.lookup <= !(overlong_flag || byte_count >= 8'(MAX_NAME_LEN));
          req.code <= StLong;
          req.hash <= (hash_next == '0) ? 32'd1 : hash_next;
          req.len  <= (byte_count < 8'(MAX_NAME_LEN)) ? byte_count + 8'd1 : byte_count;
          running_hash <= FnvOffset;
          byte_count <= '0;
          overlong_flag <= 1'b0;
        end else begin
          running_hash <= hash_next;
          if (byte_count < 8'(MAX_NAME_LEN)) byte_count <= byte_count + 8'd1;
          else overlong_flag <= 1'b1;
        end
      end
    end
  end
endmodule

// File: design/cfn_back.sv
// Back: probe the table, compare stored characters, insert on a miss
module cfn_back import cfn_pkg::*; #(
  parameter int unsigned TABLE_SLOTS  = TableSlotsDef,
  parameter int unsigned MAX_ATOMS    = MaxAtomsDef,
  parameter int unsigned MAX_NAME_LEN = MaxNameLenDef,
  parameter int unsigned STORE_BYTES  = StoreBytesDef,
  localparam int unsigned NW = $clog2(MAX_NAME_LEN),
  localparam int unsigned TW = $clog2(TABLE_SLOTS),
  localparam int unsigned AW = $clog2(MAX_ATOMS),
  localparam int unsigned SW = $clog2(STORE_BYTES)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  cfn_req_t       req,
  output logic           req_ready,
  output logic [NW-1:0]  stage_addr,
  input  logic [7:0]     stage_data,
  output logic           stage_release,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [6:0]     atom_index,
  output logic [2:0]     status
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLR   = 9'b000000010,
    S_PRB   = 9'b000000100,
    S_PRBW  = 9'b000001000,
    S_ENT   = 9'b000010000,
    S_CMP   = 9'b000100000,
    S_CMPW  = 9'b001000000,
    S_INS   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic [AW-1:0] probe_table [TABLE_SLOTS];
  logic [31:0]   entry_hash  [MAX_ATOMS];
  logic [7:0]    entry_length[MAX_ATOMS];
  logic [SW:0]   entry_start [MAX_ATOMS];
  logic [7:0]    char_store  [STORE_BYTES];

  cfn_req_t      cur;
  logic [TW:0]   clr;
  logic [TW-1:0] slot;
  logic [TW:0]   nprobe;
  logic [AW-1:0] idx;
  logic [31:0]   e_hash;
  logic [7:0]    e_len;
  logic [SW:0]   e_start;
  logic [7:0]    ci;
  logic [7:0]    s_data;
  logic [AW:0]   next_atom;
  logic [SW:0]   store_fill;
  logic          pt_we;
  logic [TW-1:0] pt_waddr;
  logic [AW-1:0] pt_wdata;
  logic          cs_we;
  logic [SW-1:0] cs_waddr;
  logic [SW:0]   rd_addr;
  logic          room;

  assign req_ready = (state == S_IDLE) && !out_valid;
  assign stage_addr = ci[NW-1:0];
  assign rd_addr = e_start + (SW+1)'(ci);
  assign room = (next_atom < (AW+1)'(MAX_ATOMS)) &&
                ((32'(next_atom) + 32'd1) * 32'd2 <= 32'(TABLE_SLOTS)) &&
                (32'(store_fill) + 32'(cur.len) <= 32'(STORE_BYTES));

  // Memories
  always_ff @(posedge clk) begin
    if (pt_we) probe_table[pt_waddr] <= pt_wdata;
    idx <= probe_table[slot];
  end
  always_ff @(posedge clk) begin
    if (state == S_INS && ci == 8'd0 && room) begin
      entry_hash[next_atom[AW-1:0]]   <= cur.hash;
      entry_length[next_atom[AW-1:0]] <= cur.len;
      entry_start[next_atom[AW-1:0]]  <= store_fill;
    end
    e_hash  <= entry_hash[idx];
    e_len   <= entry_length[idx];
    e_start <= entry_start[idx];
  end
  always_ff @(posedge clk) begin
    if (cs_we) char_store[cs_waddr] <= stage_data;
    s_data <= char_store[rd_addr[SW-1:0]];
  end

  always_comb begin
    pt_we = 1'b0; pt_waddr = slot; pt_wdata = next_atom[AW-1:0];
    if (state == S_CLR) begin
      pt_we = 1'b1; pt_waddr = clr[TW-1:0]; pt_wdata = '0;
    end else if (state == S_INS && ci == cur.len && room) begin
      pt_we = 1'b1;
    end
  end
  // Stage data is registered from the stage address, so it lags the address during copy
  assign cs_we = (state == S_INS) && room && ci != 8'd0;
  assign cs_waddr = SW'(store_fill + (SW+1)'(ci) - (SW+1)'(1));

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr <= '0; out_valid <= 1'b0; stage_release <= 1'b0;
      next_atom <= (AW+1)'(1); store_fill <= '0;
    end else begin
      stage_release <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == (TW+1)'(TABLE_SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (req_valid && req_ready) begin
          cur <= req;
          if (req.lookup) begin
            slot <= req.hash[TW-1:0]; nprobe <= '0; state <= S_PRB;
          end else begin
            atom_index <= '0; status <= req.code; out_valid <= 1'b1;
          end
        end
        S_PRB: state <= S_PRBW;   // probe table read
        S_PRBW: begin
          if (idx == '0) begin
            ci <= '0; state <= S_INS;
          end else state <= S_ENT;
        end
        S_ENT: begin            // entry fields read
          ci <= '0; state <= S_CMP;
        end
        S_CMP: begin
          if (e_hash != cur.hash || e_len != cur.len) begin
            if (nprobe == (TW+1)'(TABLE_SLOTS - 1)) begin
              state <= S_OUT; status <= StFull; atom_index <= '0;
            end else begin
              slot <= slot + 1'b1; nprobe <= nprobe + 1'b1; state <= S_PRB;
            end
          end else if (ci == cur.len) begin
            atom_index <= 7'(idx); status <= StFound; state <= S_OUT;
          end else state <= S_CMPW;
        end
        S_CMPW: begin           // read of char pair pending
          if (s_data != stage_data) begin
            if (nprobe == (TW+1)'(TABLE_SLOTS - 1)) begin
              status <= StFull; atom_index <= '0; state <= S_OUT;
            end else begin
              slot <= slot + 1'b1; nprobe <= nprobe + 1'b1; state <= S_PRB;
            end
          end else begin
            ci <= ci + 8'd1; state <= S_CMP;
          end
        end
        S_INS: begin
          if (!room) begin
            status <= StFull; atom_index <= '0; state <= S_OUT;
          end else if (ci == cur.len) begin
            atom_index <= 7'(next_atom); status <= StInserted;
            next_atom <= next_atom + 1'b1;
            store_fill <= store_fill + (SW+1)'(cur.len);
            state <= S_OUT;
          end else ci <= ci + 8'd1;
        end
        S_OUT: if (!out_valid) begin
          out_valid <= 1'b1; stage_release <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: design/case_folded_name_intern_table_top.sv
// Channel | Signals                              | Direction
// in      | in_valid/in_ready, name_byte, last_byte, empty_name | request in
// out     | out_valid/out_ready, atom_index, status | result out
// A non-final byte is taken whenever in_ready is high. A final byte holds the input off
// until its result is issued: a lookup reads the probed slots and compares the
// stored characters pair by pair, and an insert copies the name into the store;
// the single read port on each memory sets this pace.
// After reset the probe table is swept, one slot a cycle,
// with no lookup started. One request sits between front and back.
module case_folded_name_intern_table_top import cfn_pkg::*; #(
  parameter int unsigned TABLE_SLOTS  = TableSlotsDef,
  parameter int unsigned MAX_ATOMS    = MaxAtomsDef,
  parameter int unsigned MAX_NAME_LEN = MaxNameLenDef,
  parameter int unsigned STORE_BYTES  = StoreBytesDef
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] name_byte,
  input  logic       last_byte,
  input  logic       empty_name,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] atom_index,
  output logic [2:0] status
);
  localparam int unsigned NW = $clog2(MAX_NAME_LEN);
  logic          req_valid, req_ready, stage_release;
  cfn_req_t      req;
  logic [NW-1:0] stage_addr;
  logic [7:0]    stage_data;

  cfn_front #(.MAX_NAME_LEN(MAX_NAME_LEN)) u_front (
    .clk, .rst, .name_byte, .last_byte, .empty_name, .in_valid, .in_ready,
    .req_valid, .req, .req_ready, .stage_addr, .stage_data, .stage_release
  );

  cfn_back #(.TABLE_SLOTS(TABLE_SLOTS), .MAX_ATOMS(MAX_ATOMS),
             .MAX_NAME_LEN(MAX_NAME_LEN), .STORE_BYTES(STORE_BYTES)) u_back (
    .clk, .rst, .req_valid, .req, .req_ready, .stage_addr, .stage_data,
    .stage_release, .out_valid, .out_ready, .atom_index, .status
  );
endmodule

// File: design/cfn_checker.sv
`include "case_folded_name_intern_table_top_macros.svh"
// Port-level checks on the intern table
module cfn_checker import cfn_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] atom_index,
  input logic [2:0] status
);
  `CFN_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !in_ready, in_valid,
    "request withdrawn before acceptance")
  `CFN_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(status), "result dropped while stalled")
  `CFN_ASSERT_IMP(a_zero_atom, clk, rst,
    out_valid && (status == StEmpty || status == StFull || status == StLong),
    atom_index == 7'd0, "failed status with nonzero atom")
  `CFN_ASSERT_IMP(a_real_atom, clk, rst,
    out_valid && (status == StFound || status == StInserted),
    atom_index != 7'd0, "atom zero returned as found or inserted")
  `CFN_ASSERT_IMP(a_code, clk, rst, out_valid, status <= StLong,
    "status code out of range")
endmodule

bind case_folded_name_intern_table_top cfn_checker u_cfn_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .atom_index, .status
);

// File: bench/tb_top.sv
class intern_scoreboard;
  typedef struct {
    logic [6:0] atom;
    logic [2:0] st;
  } intern_res_t;

  // predictor state
  logic [7:0]  staging [64];
  logic [31:0] hash_acc;
  int unsigned nbytes;
  bit          too_long;
  int unsigned probe [256];
  logic [31:0] ent_hash [128];
  int unsigned ent_len [128];
  int unsigned ent_start [128];
  logic [7:0]  chars [4096];
  int unsigned next_id;
  int unsigned fill;

  intern_res_t pending[$];
  int errors;
  int n_checked;
  int n_found;
  int n_inserted;
  int n_full;

  function new();
    foreach (probe[i]) probe[i] = 0;
    next_id = 1;
    fill = 0;
    errors = 0;
    n_checked = 0;
    n_found = 0;
    n_inserted = 0;
    n_full = 0;
    restart();
  endfunction

  function void restart();
    hash_acc = cfn_pkg::FnvOffset;
    nbytes = 0;
    too_long = 0;
  endfunction

  function bit entry_same(int unsigned idx, logic [31:0] h);
    if (ent_hash[idx] != h || ent_len[idx] != nbytes) return 0;
    for (int i = 0; i < nbytes; i++)
      if (chars[ent_start[idx] + i] != staging[i]) return 0;
    return 1;
  endfunction

  function intern_res_t resolve();
    intern_res_t r;
    logic [31:0] h;
    int unsigned j;
    bit seen_empty;
    h = (hash_acc == 0) ? 32'd1 : hash_acc;
    j = h & 255;
    seen_empty = 0;
    for (int n = 0; n < 256; n++) begin
      if (probe[j] == 0) begin
        seen_empty = 1;
        break;
      end
      if (entry_same(probe[j], h)) begin
        r.atom = probe[j][6:0];
        r.st = cfn_pkg::StFound;
        return r;
      end
      j = (j + 1) & 255;
    end
    if (!seen_empty || next_id >= 128 || (next_id + 1) * 2 > 256 || fill + nbytes > 4096) begin
      r.atom = '0;
      r.st = cfn_pkg::StFull;
      return r;
    end
    ent_hash[next_id] = h;
    ent_len[next_id] = nbytes;
    ent_start[next_id] = fill;
    for (int i = 0; i < nbytes; i++) chars[fill + i] = staging[i];
    fill += nbytes;
    probe[j] = next_id;
    r.atom = next_id[6:0];
    r.st = cfn_pkg::StInserted;
    next_id++;
    return r;
  endfunction

  // Note one accepted request
  function void note_request(logic [7:0] b, logic last, logic empty);
    intern_res_t r;
    logic [7:0] c;
    if (empty) begin
      restart();
      r.atom = '0;
      r.st = cfn_pkg::StEmpty;
      pending.push_back(r);
      return;
    end
    c = (b >= 8'd65 && b <= 8'd90) ? b + 8'd32 : b;
    hash_acc = (hash_acc ^ {24'd0, c}) * cfn_pkg::FnvPrime;
    if (nbytes < 64) begin
      staging[nbytes] = c;
      nbytes++;
    end else begin
      too_long = 1;
    end
    if (!last) return;
    if (too_long) begin
      r.atom = '0;
      r.st = cfn_pkg::StLong;
    end else begin
      r = resolve();
    end
    pending.push_back(r);
    restart();
  endfunction

  // Compare one result with the oldest expectation
  function void check_result(logic [6:0] atom, logic [2:0] st);
    intern_res_t e;
    n_checked++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result atom=%0d status=%0d", $time, atom, st);
      errors++;
      return;
    end
    e = pending.pop_front();
    case (e.st)
      cfn_pkg::StFound: n_found++;
      cfn_pkg::StInserted: n_inserted++;
      cfn_pkg::StFull: n_full++;
      default: ;
    endcase
    if (atom !== e.atom) begin
      $display("%0t: atom_index expected %0d actual %0d", $time, e.atom, atom);
      errors++;
    end
    if (st !== e.st) begin
      $display("%0t: status expected %0d actual %0d", $time, e.st, st);
      errors++;
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 20000;

  logic       clk = 0;
  logic       rst = 1;
  logic       in_valid = 0;
  logic       in_ready;
  logic [7:0] name_byte = 0;
  logic       last_byte = 0;
  logic       empty_name = 0;
  logic       out_valid;
  logic       out_ready = 0;
  logic [6:0] atom_index;
  logic [2:0] status;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  int n_requests = 0;
  intern_scoreboard sb;

  // Pool of names for repeat hits
  logic [7:0] pool [16][8];
  int pool_len [16];

  case_folded_name_intern_table_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .name_byte(name_byte), .last_byte(last_byte), .empty_name(empty_name),
    .out_valid(out_valid), .out_ready(out_ready),
    .atom_index(atom_index), .status(status)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Randomize receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Track requests, results and the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_request(name_byte, last_byte, empty_name);
        n_requests++;
      end
      if (out_valid && out_ready) sb.check_result(atom_index, status);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchLimit) begin
          $display("%0t: watchdog expired", $time);
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  // Drive one request and hold it until accepted
  task automatic send_byte(logic [7:0] b, logic last, logic empty);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    name_byte <= b;
    last_byte <= last;
    empty_name <= empty;
    do @(posedge clk); while (!in_ready);
    // in_valid stays high; the next send may follow at this same edge
  endtask

  task automatic send_name(logic [7:0] bytes [], int len);
    for (int i = 0; i < len; i++) send_byte(bytes[i], i == len - 1, 1'b0);
  endtask

  task automatic random_name(int maxlen);
    logic [7:0] b [];
    int len;
    len = $urandom_range(maxlen, 1);
    b = new[len];
    foreach (b[i]) b[i] = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                          : 8'($urandom_range(90, 65) + ($urandom_range(1) ? 32 : 0));
    send_name(b, len);
  endtask

  task automatic pool_name(int k, bit flip_case);
    logic [7:0] b [];
    b = new[pool_len[k]];
    foreach (b[i]) begin
      b[i] = pool[k][i];
      if (flip_case && $urandom_range(1)) b[i] = b[i] ^ 8'h20;
    end
    send_name(b, pool_len[k]);
  endtask

  task automatic run_phase(int idle, int stall, int count);
    int r;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 45) pool_name($urandom_range(15), 1'b1);
      else if (r < 85) random_name(8);
      else if (r < 90) random_name(70);
      else if (r < 95) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      else begin
        // broken name: one partial byte then empty
        send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      end
    end
  endtask

  initial begin
    logic [7:0] nm [];
    int limit;
    sb = new();
    for (int k = 0; k < 16; k++) begin
      pool_len[k] = $urandom_range(8, 1);
      for (int i = 0; i < 8; i++) pool[k][i] = 8'($urandom_range(122, 97));
    end
    repeat (10) @(posedge clk);
    rst <= 0;

    // Directed: extremes, folding, empty, overlong, found
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h41, 1'b1, 1'b0);
    send_byte(8'h61, 1'b1, 1'b0);
    send_byte(8'h5A, 1'b1, 1'b0);
    send_byte(8'h7A, 1'b1, 1'b0);
    send_byte(8'h40, 1'b1, 1'b0);
    send_byte(8'h5B, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    nm = new[2];
    nm[0] = 8'h41;
    nm[1] = 8'h62;
    send_name(nm, 2);
    nm[0] = 8'h61;
    nm[1] = 8'h42;
    send_name(nm, 2);
    nm = new[64];
    foreach (nm[i]) nm[i] = 8'h51;
    send_name(nm, 64);
    send_name(nm, 64);
    nm = new[65];
    foreach (nm[i]) nm[i] = 8'h52;
    send_name(nm, 65);
    send_byte(8'h43, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b1);

    run_phase(0, 0, 10);
    run_phase(64, 0, 10);
    run_phase(0, 64, 10);
    run_phase(7, 7, 10);
    // Fill the table with distinct one-byte names to reach the no-room case
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int k = 0; k < 110; k++) send_byte(8'(128 + k), 1'b1, 1'b0);
    in_valid <= 1'b0;

    limit = 0;
    while (sb.pending.size() != 0 && limit < WatchLimit) begin
      @(posedge clk);
      limit++;
    end
    repeat (600) @(posedge clk);
    $display("Sent %0d byte requests, checked %0d results (found %0d, inserted %0d, full %0d).",
             n_requests, sb.n_checked, sb.n_found, sb.n_inserted, sb.n_full);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0t: %0d errors, %0d results missing", $time, sb.errors, sb.pending.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// File: case_folded_name_intern_table_top.f
+incdir+design
design/cfn_pkg.sv
design/cfn_front.sv
design/cfn_back.sv
design/case_folded_name_intern_table_top.sv
design/cfn_checker.sv
bench/tb_top.sv
